FILE: design/szap_pkg.sv
// Shared constants, types and arctangent table for the solar zenith angle pipeline.
package szap_pkg;

   localparam int LON_W = 20;
   localparam int LAT_W = 18;
   localparam int LT_W = 19;
   localparam int Q16_W = 18;
   localparam int ZEN_W = 18;
   localparam int CSR_DATA_W = 20;
   localparam int ANG_W = 34;
   localparam int SQ_W = 64;
   localparam int SQRT_STEPS = 32;
   localparam int MAX_STAGES = 24;
   localparam int CORDIC_STAGES_DEF = 16;

   localparam logic signed [ANG_W-1:0] PI_Q30 = 34'sd3373259426;
   localparam logic signed [ANG_W-1:0] HALF_PI_Q30 = 34'sd1686629713;
   localparam logic signed [ANG_W-1:0] GAIN_Q30 = 34'sd652032874;
   localparam logic signed [ANG_W-1:0] ROUND_Q30 = 34'sd8192;

   typedef enum logic [1:0] {
      CSR_LON_OFFSET = 2'd0,
      CSR_SIN_DEC    = 2'd1,
      CSR_COS_DEC    = 2'd2
   } csr_index_type;

   typedef logic signed [ANG_W-1:0] ang_type;

   typedef struct packed {
      ang_type x_lat;
      ang_type y_lat;
      ang_type z_lat;
      logic    neg_lat;
      ang_type x_h;
      ang_type y_h;
      ang_type z_h;
      logic    neg_h;
   } rot_type;

   typedef struct packed {
      logic [SQ_W-1:0] v;
      logic [SQ_W-1:0] r;
   } sqrt_type;

   typedef struct packed {
      ang_type x;
      ang_type y;
      ang_type z;
   } vec_type;

   function automatic ang_type atan_q30(input int unsigned idx);
      ang_type a;
      case (idx)
         0: a = 34'sd843314857;
         1: a = 34'sd497837829;
         2: a = 34'sd263043837;
         3: a = 34'sd133525159;
         4: a = 34'sd67021687;
         5: a = 34'sd33543516;
         6: a = 34'sd16775851;
         7: a = 34'sd8388437;
         8: a = 34'sd4194283;
         9: a = 34'sd2097149;
         10: a = 34'sd1048576;
         11: a = 34'sd524288;
         12: a = 34'sd262144;
         13: a = 34'sd131072;
         14: a = 34'sd65536;
         15: a = 34'sd32768;
         16: a = 34'sd16384;
         17: a = 34'sd8192;
         18: a = 34'sd4096;
         19: a = 34'sd2048;
         20: a = 34'sd1024;
         21: a = 34'sd512;
         22: a = 34'sd256;
         23: a = 34'sd128;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

FILE: design/szap_if.sv
// Handshake channel interfaces: grid point request, angle response, register write.
interface szap_req_if;
   logic valid;
   logic ready;
   logic signed [szap_pkg::LON_W-1:0] geo_lon;
   logic signed [szap_pkg::LAT_W-1:0] geo_lat;
   modport source (output valid, output geo_lon, output geo_lat, input ready);
   modport sink (input valid, input geo_lon, input geo_lat, output ready);
endinterface

interface szap_rsp_if;
   logic valid;
   logic ready;
   logic [szap_pkg::LT_W-1:0] local_time;
   logic signed [szap_pkg::Q16_W-1:0] cos_zenith;
   logic [szap_pkg::ZEN_W-1:0] zenith;
   modport source (output valid, output local_time, output cos_zenith, output zenith,
                   input ready);
   modport sink (input valid, input local_time, input cos_zenith, input zenith,
                 output ready);
endinterface

interface szap_csr_if;
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [szap_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/solar_zenith_angle.sv
// Solar zenith angle pipeline: local time wrap, sine/cosine, cos(sza) and arccosine.
// Accepts one grid point per cycle and returns one result per point, in order. The pipe is
// three registers of local time wrap and angle reduction, one rotation cell per CORDIC stage,
// five registers of products and saturation, 32 square root digit cells, one swap register,
// one vectoring cell per stage and the output register. The whole pipe holds when a result
// is waiting and not taken. CORDIC_STAGES above 24 acts as 24.
module solar_zenith_angle #(
   parameter int CORDIC_STAGES = szap_pkg::CORDIC_STAGES_DEF
) (
   input logic        clock,
   input logic        reset,
   szap_req_if.sink   req_ch,
   szap_rsp_if.source rsp_ch,
   szap_csr_if.sink   csr_ch
);
   import szap_pkg::*;

   localparam int NSTG = (CORDIC_STAGES > MAX_STAGES) ? MAX_STAGES : CORDIC_STAGES;
   localparam int LT_TAG_W = LT_W;
   localparam int CZ_TAG_W = LT_W + Q16_W;

   localparam logic signed [20:0] TWO_PI_21 = 21'sd411775;
   localparam logic signed [20:0] FOUR_PI_21 = 21'sd823550;
   localparam logic signed [19:0] PI_20 = 20'sd205887;
   localparam logic signed [21:0] ONE_Q16_22 = 22'sd65536;
   localparam logic signed [20:0] ZEN_MAX_21 = 21'sd205887;

   logic lon_offset_ff_sign;
   logic signed [LON_W-1:0] lon_offset_ff;
   logic signed [Q16_W-1:0] sin_dec_ff;
   logic signed [Q16_W-1:0] cos_dec_ff;

   logic adv;

   logic s0_v_ff, s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff, s6_v_ff, s7_v_ff;
   logic s8_v_ff, s9_v_ff;

   logic signed [20:0] sum_in, sum_ff;
   logic signed [LAT_W-1:0] lat0_ff, lat1_ff;
   logic signed [21:0] wrap;
   logic [LT_W-1:0] lt_in, lt1_ff, lt3_ff, lt4_ff, lt5_ff, lt6_ff, lt7_ff;

   rot_type rot_in, rot0_ff;
   logic [LT_W-1:0] lt2_ff;
   logic signed [19:0] h_q16;

   rot_type rot_d [0:NSTG];
   logic rot_v [0:NSTG];
   logic [LT_TAG_W-1:0] rot_t [0:NSTG];

   logic signed [Q16_W-1:0] slat_ff, clat_ff, ch_ff, ch4_ff;
   logic signed [35:0] p1_ff, p2_ff, p2_5_ff;
   logic signed [18:0] prod_in;
   logic signed [36:0] p3_ff;
   logic signed [37:0] sum6;
   logic signed [21:0] cz_r;
   logic signed [Q16_W-1:0] cz_in, cz6_ff, cz7_ff;
   logic signed [35:0] sq;
   logic [32:0] rem_ff;

   sqrt_type sq_d [0:SQRT_STEPS];
   logic sq_v [0:SQRT_STEPS];
   logic [CZ_TAG_W-1:0] sq_t [0:SQRT_STEPS];

   vec_type vec_in, vec0_ff;
   logic [CZ_TAG_W-1:0] tag8_ff;
   ang_type cz_q30, root_q30;

   vec_type vec_d [0:NSTG];
   logic vec_v [0:NSTG];
   logic [CZ_TAG_W-1:0] vec_t [0:NSTG];

   logic signed [20:0] zen_r;
   logic [ZEN_W-1:0] zen_in, zen_ff;
   logic [LT_W-1:0] lt9_ff;
   logic signed [Q16_W-1:0] cz9_ff;

   function automatic logic signed [Q16_W-1:0] to_q16(input ang_type v, input logic neg);
      ang_type t;
      ang_type s;
      logic signed [20:0] r;
      t = neg ? -v : v;
      s = (t + ROUND_Q30) >>> 14;
      r = s[20:0];
      if (r > 21'sd65536) begin
         return 18'sd65536;
      end else if (r < -21'sd65536) begin
         return -18'sd65536;
      end
      return r[Q16_W-1:0];
   endfunction

   // configuration registers
   assign csr_ch.ready = 1'b1;
   assign lon_offset_ff_sign = lon_offset_ff[LON_W-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         lon_offset_ff <= '0;
         sin_dec_ff <= '0;
         cos_dec_ff <= 18'sd65536;
      end else if (csr_ch.valid) begin
         unique case (csr_ch.index)
            CSR_LON_OFFSET: lon_offset_ff <= csr_ch.data[LON_W-1:0];
            CSR_SIN_DEC:    sin_dec_ff <= csr_ch.data[Q16_W-1:0];
            CSR_COS_DEC:    cos_dec_ff <= csr_ch.data[Q16_W-1:0];
            default: ;
         endcase
      end
   end

   assign adv = !s9_v_ff || rsp_ch.ready;
   assign req_ch.ready = adv;

   // local time sum and floor modulo 2pi
   assign sum_in = {req_ch.geo_lon[LON_W-1], req_ch.geo_lon}
                 + {lon_offset_ff_sign, lon_offset_ff};

   always_comb begin
      if (sum_ff >= FOUR_PI_21) begin
         wrap = 22'(sum_ff) - 22'(FOUR_PI_21);
      end else if (sum_ff >= TWO_PI_21) begin
         wrap = 22'(sum_ff) - 22'(TWO_PI_21);
      end else if (!sum_ff[20]) begin
         wrap = 22'(sum_ff);
      end else if (sum_ff >= -TWO_PI_21) begin
         wrap = 22'(sum_ff) + 22'(TWO_PI_21);
      end else if (sum_ff >= -FOUR_PI_21) begin
         wrap = 22'(sum_ff) + 22'(FOUR_PI_21);
      end else begin
         wrap = 22'(sum_ff) + 22'(FOUR_PI_21) + 22'(TWO_PI_21);
      end
      lt_in = wrap[LT_W-1:0];
   end

   // angle reduction into the CORDIC range
   always_comb begin
      rot_in.x_lat = GAIN_Q30;
      rot_in.y_lat = '0;
      rot_in.z_lat = {{2{lat1_ff[LAT_W-1]}}, lat1_ff, 14'b0};
      rot_in.neg_lat = 1'b0;
      if (rot_in.z_lat > HALF_PI_Q30) begin
         rot_in.z_lat = rot_in.z_lat - PI_Q30;
         rot_in.neg_lat = 1'b1;
      end else if (rot_in.z_lat < -HALF_PI_Q30) begin
         rot_in.z_lat = rot_in.z_lat + PI_Q30;
         rot_in.neg_lat = 1'b1;
      end
      h_q16 = $signed({1'b0, lt1_ff}) - PI_20;
      rot_in.x_h = GAIN_Q30;
      rot_in.y_h = '0;
      rot_in.z_h = {h_q16, 14'b0};
      rot_in.neg_h = 1'b0;
      if (rot_in.z_h > HALF_PI_Q30) begin
         rot_in.z_h = rot_in.z_h - PI_Q30;
         rot_in.neg_h = 1'b1;
      end else if (rot_in.z_h < -HALF_PI_Q30) begin
         rot_in.z_h = rot_in.z_h + PI_Q30;
         rot_in.neg_h = 1'b1;
      end
   end

   assign rot_d[0] = rot0_ff;
   assign rot_v[0] = s2_v_ff;
   assign rot_t[0] = lt2_ff;

   for (genvar k = 0; k < NSTG; k++) begin : g_rot
      szap_rot_cell #(.SHIFT(k), .TAG_W(LT_TAG_W)) u_cell (
         .clock(clock), .reset(reset), .en(adv),
         .in_valid(rot_v[k]), .in_data(rot_d[k]), .in_tag(rot_t[k]),
         .out_valid(rot_v[k+1]), .out_data(rot_d[k+1]), .out_tag(rot_t[k+1])
      );
   end

   // products and saturation of cos(sza)
   assign prod_in = 19'((p1_ff + 36'sd32768) >>> 16);
   assign sum6 = 38'(p2_5_ff) + 38'(p3_ff);
   assign cz_r = 22'((sum6 + 38'sd32768) >>> 16);

   always_comb begin
      if (cz_r > ONE_Q16_22) begin
         cz_in = 18'sd65536;
      end else if (cz_r < -ONE_Q16_22) begin
         cz_in = -18'sd65536;
      end else begin
         cz_in = cz_r[Q16_W-1:0];
      end
   end

   assign sq = cz6_ff * cz6_ff;

   assign sq_d[0] = '{v: {3'b0, rem_ff, 28'b0}, r: '0};
   assign sq_v[0] = s7_v_ff;
   assign sq_t[0] = {lt7_ff, cz7_ff};

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      szap_sqrt_cell #(.STEP(k), .TAG_W(CZ_TAG_W)) u_cell (
         .clock(clock), .reset(reset), .en(adv),
         .in_valid(sq_v[k]), .in_data(sq_d[k]), .in_tag(sq_t[k]),
         .out_valid(sq_v[k+1]), .out_data(sq_d[k+1]), .out_tag(sq_t[k+1])
      );
   end

   // arccosine start vector (c, sqrt(1 - c*c)), rotated by pi/2 when c is negative
   always_comb begin
      cz_q30 = {{2{sq_t[SQRT_STEPS][Q16_W-1]}}, sq_t[SQRT_STEPS][Q16_W-1:0], 14'b0};
      root_q30 = {3'b0, sq_d[SQRT_STEPS].r[30:0]};
      if (cz_q30[ANG_W-1]) begin
         vec_in.x = root_q30;
         vec_in.y = -cz_q30;
         vec_in.z = HALF_PI_Q30;
      end else begin
         vec_in.x = cz_q30;
         vec_in.y = root_q30;
         vec_in.z = '0;
      end
   end

   assign vec_d[0] = vec0_ff;
   assign vec_v[0] = s8_v_ff;
   assign vec_t[0] = tag8_ff;

   for (genvar k = 0; k < NSTG; k++) begin : g_vec
      szap_vec_cell #(.SHIFT(k), .TAG_W(CZ_TAG_W)) u_cell (
         .clock(clock), .reset(reset), .en(adv),
         .in_valid(vec_v[k]), .in_data(vec_d[k]), .in_tag(vec_t[k]),
         .out_valid(vec_v[k+1]), .out_data(vec_d[k+1]), .out_tag(vec_t[k+1])
      );
   end

   always_comb begin
      zen_r = 21'((vec_d[NSTG].z + ROUND_Q30) >>> 14);
      if (zen_r[20]) begin
         zen_in = '0;
      end else if (zen_r > ZEN_MAX_21) begin
         zen_in = ZEN_W'(ZEN_MAX_21);
      end else begin
         zen_in = zen_r[ZEN_W-1:0];
      end
   end

   // pipeline valids
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff <= 1'b0;
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         s5_v_ff <= 1'b0;
         s6_v_ff <= 1'b0;
         s7_v_ff <= 1'b0;
         s8_v_ff <= 1'b0;
         s9_v_ff <= 1'b0;
      end else if (adv) begin
         s0_v_ff <= req_ch.valid;
         s1_v_ff <= s0_v_ff;
         s2_v_ff <= s1_v_ff;
         s3_v_ff <= rot_v[NSTG];
         s4_v_ff <= s3_v_ff;
         s5_v_ff <= s4_v_ff;
         s6_v_ff <= s5_v_ff;
         s7_v_ff <= s6_v_ff;
         s8_v_ff <= sq_v[SQRT_STEPS];
         s9_v_ff <= vec_v[NSTG];
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (adv) begin
         sum_ff <= sum_in;
         lat0_ff <= req_ch.geo_lat;
         lt1_ff <= lt_in;
         lat1_ff <= lat0_ff;
         rot0_ff <= rot_in;
         lt2_ff <= lt1_ff;
         slat_ff <= to_q16(rot_d[NSTG].y_lat, rot_d[NSTG].neg_lat);
         clat_ff <= to_q16(rot_d[NSTG].x_lat, rot_d[NSTG].neg_lat);
         ch_ff <= to_q16(rot_d[NSTG].x_h, rot_d[NSTG].neg_h);
         lt3_ff <= rot_t[NSTG];
         p1_ff <= cos_dec_ff * clat_ff;
         p2_ff <= sin_dec_ff * slat_ff;
         ch4_ff <= ch_ff;
         lt4_ff <= lt3_ff;
         p3_ff <= prod_in * ch4_ff;
         p2_5_ff <= p2_ff;
         lt5_ff <= lt4_ff;
         cz6_ff <= cz_in;
         lt6_ff <= lt5_ff;
         rem_ff <= 33'd4294967296 - sq[32:0];
         cz7_ff <= cz6_ff;
         lt7_ff <= lt6_ff;
         vec0_ff <= vec_in;
         tag8_ff <= sq_t[SQRT_STEPS];
         zen_ff <= zen_in;
         lt9_ff <= vec_t[NSTG][CZ_TAG_W-1:Q16_W];
         cz9_ff <= vec_t[NSTG][Q16_W-1:0];
      end
   end

   assign rsp_ch.valid = s9_v_ff;
   assign rsp_ch.local_time = lt9_ff;
   assign rsp_ch.cos_zenith = cz9_ff;
   assign rsp_ch.zenith = zen_ff;
endmodule

FILE: design/szap_rot_cell.sv
// One rotation-mode CORDIC iteration for the latitude and hour angles.
module szap_rot_cell #(
   parameter int SHIFT = 0,
   parameter int TAG_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  szap_pkg::rot_type  in_data,
   input  logic [TAG_W-1:0]   in_tag,
   output logic               out_valid,
   output szap_pkg::rot_type  out_data,
   output logic [TAG_W-1:0]   out_tag
);
   import szap_pkg::*;

   localparam ang_type ATAN = atan_q30(SHIFT);

   rot_type data_in;
   rot_type data_ff;
   logic [TAG_W-1:0] tag_ff;
   logic valid_ff;

   always_comb begin
      data_in = in_data;
      if (!in_data.z_lat[ANG_W-1]) begin
         data_in.x_lat = in_data.x_lat - (in_data.y_lat >>> SHIFT);
         data_in.y_lat = in_data.y_lat + (in_data.x_lat >>> SHIFT);
         data_in.z_lat = in_data.z_lat - ATAN;
      end else begin
         data_in.x_lat = in_data.x_lat + (in_data.y_lat >>> SHIFT);
         data_in.y_lat = in_data.y_lat - (in_data.x_lat >>> SHIFT);
         data_in.z_lat = in_data.z_lat + ATAN;
      end
      if (!in_data.z_h[ANG_W-1]) begin
         data_in.x_h = in_data.x_h - (in_data.y_h >>> SHIFT);
         data_in.y_h = in_data.y_h + (in_data.x_h >>> SHIFT);
         data_in.z_h = in_data.z_h - ATAN;
      end else begin
         data_in.x_h = in_data.x_h + (in_data.y_h >>> SHIFT);
         data_in.y_h = in_data.y_h - (in_data.x_h >>> SHIFT);
         data_in.z_h = in_data.z_h + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;
   assign out_tag = tag_ff;
endmodule

FILE: design/szap_sqrt_cell.sv
// One digit step of the bit-serial integer square root.
module szap_sqrt_cell #(
   parameter int STEP = 0,
   parameter int TAG_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  szap_pkg::sqrt_type in_data,
   input  logic [TAG_W-1:0]   in_tag,
   output logic               out_valid,
   output szap_pkg::sqrt_type out_data,
   output logic [TAG_W-1:0]   out_tag
);
   import szap_pkg::*;

   localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQRT_STEPS - 1 - STEP));

   sqrt_type data_in;
   sqrt_type data_ff;
   logic [TAG_W-1:0] tag_ff;
   logic valid_ff;
   logic [SQ_W-1:0] trial;

   always_comb begin
      trial = in_data.r + BIT;
      if (in_data.v >= trial) begin
         data_in.v = in_data.v - trial;
         data_in.r = (in_data.r >> 1) + BIT;
      end else begin
         data_in.v = in_data.v;
         data_in.r = in_data.r >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;
   assign out_tag = tag_ff;
endmodule

FILE: design/szap_vec_cell.sv
// One vectoring-mode CORDIC iteration for the arccosine.
module szap_vec_cell #(
   parameter int SHIFT = 0,
   parameter int TAG_W = 1
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               in_valid,
   input  szap_pkg::vec_type  in_data,
   input  logic [TAG_W-1:0]   in_tag,
   output logic               out_valid,
   output szap_pkg::vec_type  out_data,
   output logic [TAG_W-1:0]   out_tag
);
   import szap_pkg::*;

   localparam ang_type ATAN = atan_q30(SHIFT);

   vec_type data_in;
   vec_type data_ff;
   logic [TAG_W-1:0] tag_ff;
   logic valid_ff;

   always_comb begin
      if (!in_data.y[ANG_W-1]) begin
         data_in.x = in_data.x + (in_data.y >>> SHIFT);
         data_in.y = in_data.y - (in_data.x >>> SHIFT);
         data_in.z = in_data.z + ATAN;
      end else begin
         data_in.x = in_data.x - (in_data.y >>> SHIFT);
         data_in.y = in_data.y + (in_data.x >>> SHIFT);
         data_in.z = in_data.z - ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
      if (en) begin
         data_ff <= data_in;
         tag_ff <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_data = data_ff;
   assign out_tag = tag_ff;
endmodule

FILE: design/szap_checker.sv
// Port-level checks for the solar zenith angle block, bound to the top level.
module szap_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [szap_pkg::LT_W-1:0]          local_time,
   input logic signed [szap_pkg::Q16_W-1:0]  cos_zenith,
   input logic [szap_pkg::ZEN_W-1:0]         zenith
);
   import szap_pkg::*;

   a_ready_follows_output: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input ready does not follow output register state");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(zenith) && $stable(cos_zenith))
      else $error("stalled item changed");

   a_ranges: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> zenith <= 18'd205887 && local_time <= 19'd411774
                    && cos_zenith <= 18'sd65536 && cos_zenith >= -18'sd65536)
      else $error("result field out of range");

   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("item present right after reset");
endmodule

bind solar_zenith_angle szap_checker u_szap_checker (
   .clock(clock),
   .reset(reset),
   .req_ready(req_ch.ready),
   .rsp_valid(rsp_ch.valid),
   .rsp_ready(rsp_ch.ready),
   .local_time(rsp_ch.local_time),
   .cos_zenith(rsp_ch.cos_zenith),
   .zenith(rsp_ch.zenith)
);
